// ----- hdl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file; they expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/cmit_pkg.sv -----
// Shared constants, types and helpers for the centre of mass and inertia block.
`default_nettype none

package cmit_pkg;

	localparam int MAX_PARTICLES_DEF = 64;

	localparam int MASS_W   = 16;
	localparam int POS_W    = 16;
	localparam int TMASS_W  = 22;
	localparam int DIAG_W   = 62;
	localparam int OFF_W    = 63;
	localparam int ENTRY_W  = 64;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ZERO_MASS = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_t;

	// Control from the sequencer to the tensor pipeline.
	typedef struct packed {
		logic clear;
		logic valid;
	} tp_ctrl_t;

	function automatic logic [ENTRY_W-1:0] pack_entry(
		input logic [MASS_W-1:0] m,
		input logic [POS_W-1:0]  x,
		input logic [POS_W-1:0]  y,
		input logic [POS_W-1:0]  z
	);
		return {z, y, x, m};
	endfunction

endpackage

`default_nettype wire

// ----- hdl/cmit_store.sv -----
// Particle store: one write port, one read port with registered read data.
`default_nettype none

module cmit_store
	import cmit_pkg::*;
#(
	parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
	localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1
) (
	input  wire logic               clk,
	input  wire logic               wr_en,
	input  wire logic [IDX_W-1:0]   wr_addr,
	input  wire logic [ENTRY_W-1:0] wr_data,
	input  wire logic               rd_en,
	input  wire logic [IDX_W-1:0]   rd_addr,
	output logic      [ENTRY_W-1:0] rd_data
);

	logic [ENTRY_W-1:0] mem [MAX_PARTICLES];
	logic [ENTRY_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ----- hdl/cmit_div.sv -----
// Shared restoring divider: signed weighted sum over unsigned mass, truncated toward zero.
`default_nettype none

module cmit_div
	import cmit_pkg::*;
#(
	parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
	localparam int CNT_W  = $clog2(MAX_PARTICLES + 1),
	localparam int MSUM_W = MASS_W + CNT_W,
	localparam int WSUM_W = 32 + CNT_W
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic signed [WSUM_W-1:0] dividend,
	input  wire logic        [MSUM_W-1:0] divisor,
	output logic                          done,
	output logic signed      [POS_W-1:0]  quotient
);

	localparam int DSH_W = MSUM_W + POS_W - 1;
	localparam int STEP_W = $clog2(POS_W);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(POS_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [WSUM_W-1:0] rem_q;
	logic [DSH_W-1:0]  dsh_q;
	logic [POS_W-1:0]  q_q;
	logic              neg_q;
	logic              ge;

	assign ge = rem_q >= WSUM_W'(dsh_q);

	// The mean of the positions lies in the 16-bit range, so sixteen quotient
	// bits are enough and the divisor starts shifted up by fifteen places.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			rem_q  <= '0;
			dsh_q  <= '0;
			q_q    <= '0;
			neg_q  <= 1'b0;
		end else begin
			done_q <= !start && busy_q && (step_q == STEP_LAST);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				neg_q  <= dividend[WSUM_W-1];
				rem_q  <= dividend[WSUM_W-1] ? WSUM_W'(-dividend) : WSUM_W'(dividend);
				dsh_q  <= {divisor, {(POS_W-1){1'b0}}};
				q_q    <= '0;
			end else if (busy_q) begin
				if (ge) begin
					rem_q <= rem_q - WSUM_W'(dsh_q);
				end
				q_q    <= {q_q[POS_W-2:0], ge};
				dsh_q  <= dsh_q >> 1;
				step_q <= step_q + 1'b1;
				if (step_q == STEP_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? $signed(~q_q + 1'b1) : $signed(q_q);

endmodule

`default_nettype wire

// ----- hdl/cmit_tensor.sv -----
// Inertia pipeline: offsets from the centre, products, mass weighting and accumulation.
`default_nettype none

module cmit_tensor
	import cmit_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire tp_ctrl_t                ctrl,
	input  wire logic [ENTRY_W-1:0]      entry,
	input  wire logic signed [POS_W-1:0] cx,
	input  wire logic signed [POS_W-1:0] cy,
	input  wire logic signed [POS_W-1:0] cz,
	output logic                         busy,
	output logic [DIAG_W-1:0]            ixx,
	output logic [DIAG_W-1:0]            iyy,
	output logic [DIAG_W-1:0]            izz,
	output logic signed [OFF_W-1:0]      ixy,
	output logic signed [OFF_W-1:0]      ixz,
	output logic signed [OFF_W-1:0]      iyz
);

	localparam int D_W   = POS_W + 1;
	localparam int P_W   = 2 * D_W;
	localparam int SQ_W  = 2 * POS_W;
	localparam int WD_W  = MASS_W + SQ_W + 1;
	localparam int WO_W  = MASS_W + 1 + P_W;

	logic [MASS_W-1:0] ent_m;
	logic signed [POS_W-1:0] ent_x, ent_y, ent_z;

	assign ent_m = entry[MASS_W-1:0];
	assign ent_x = entry[MASS_W +: POS_W];
	assign ent_y = entry[MASS_W+POS_W +: POS_W];
	assign ent_z = entry[MASS_W+2*POS_W +: POS_W];

	// Stage 2: offsets from the centre.
	logic                  v_s2;
	logic [MASS_W-1:0]     m_s2;
	logic signed [D_W-1:0] dx_s2, dy_s2, dz_s2;

	// Stage 3: squares and cross products.
	logic                  v_s3;
	logic [MASS_W-1:0]     m_s3;
	logic [SQ_W-1:0]       sqx_s3, sqy_s3, sqz_s3;
	logic signed [P_W-1:0] pxy_s3, pxz_s3, pyz_s3;

	// Stage 4: mass-weighted terms.
	logic                   v_s4;
	logic [WD_W-1:0]        wxx_s4, wyy_s4, wzz_s4;
	logic signed [WO_W-1:0] wxy_s4, wxz_s4, wyz_s4;

	logic [DIAG_W-1:0]       ixx_q, iyy_q, izz_q;
	logic signed [OFF_W-1:0] ixy_q, ixz_q, iyz_q;

	logic signed [P_W-1:0] sqx_c, sqy_c, sqz_c, pxy_c, pxz_c, pyz_c;
	logic [SQ_W:0]         syz_c, szx_c, sxy_c;
	logic [WD_W-1:0]       wxx_c, wyy_c, wzz_c;
	logic signed [MASS_W:0] ms_c;
	logic signed [WO_W-1:0] wxy_c, wxz_c, wyz_c;

	assign sqx_c = dx_s2 * dx_s2;
	assign sqy_c = dy_s2 * dy_s2;
	assign sqz_c = dz_s2 * dz_s2;
	assign pxy_c = dx_s2 * dy_s2;
	assign pxz_c = dx_s2 * dz_s2;
	assign pyz_c = dy_s2 * dz_s2;

	assign syz_c = {1'b0, sqy_s3} + {1'b0, sqz_s3};
	assign szx_c = {1'b0, sqz_s3} + {1'b0, sqx_s3};
	assign sxy_c = {1'b0, sqx_s3} + {1'b0, sqy_s3};
	assign wxx_c = m_s3 * syz_c;
	assign wyy_c = m_s3 * szx_c;
	assign wzz_c = m_s3 * sxy_c;

	assign ms_c  = {1'b0, m_s3};
	assign wxy_c = ms_c * pxy_s3;
	assign wxz_c = ms_c * pxz_s3;
	assign wyz_c = ms_c * pyz_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= ctrl.valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		m_s2   <= ent_m;
		dx_s2  <= D_W'(ent_x) - D_W'(cx);
		dy_s2  <= D_W'(ent_y) - D_W'(cy);
		dz_s2  <= D_W'(ent_z) - D_W'(cz);

		m_s3   <= m_s2;
		sqx_s3 <= sqx_c[SQ_W-1:0];
		sqy_s3 <= sqy_c[SQ_W-1:0];
		sqz_s3 <= sqz_c[SQ_W-1:0];
		pxy_s3 <= pxy_c;
		pxz_s3 <= pxz_c;
		pyz_s3 <= pyz_c;

		wxx_s4 <= wxx_c;
		wyy_s4 <= wyy_c;
		wzz_s4 <= wzz_c;
		wxy_s4 <= wxy_c;
		wxz_s4 <= wxz_c;
		wyz_s4 <= wyz_c;
	end

	// Off-diagonal terms are accumulated with their sign already flipped.
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			ixx_q <= '0;
			iyy_q <= '0;
			izz_q <= '0;
			ixy_q <= '0;
			ixz_q <= '0;
			iyz_q <= '0;
		end else if (v_s4) begin
			ixx_q <= ixx_q + DIAG_W'(wxx_s4);
			iyy_q <= iyy_q + DIAG_W'(wyy_s4);
			izz_q <= izz_q + DIAG_W'(wzz_s4);
			ixy_q <= ixy_q - OFF_W'(wxy_s4);
			ixz_q <= ixz_q - OFF_W'(wxz_s4);
			iyz_q <= iyz_q - OFF_W'(wyz_s4);
		end
	end

	assign busy = v_s2 | v_s3 | v_s4;
	assign ixx  = ixx_q;
	assign iyy  = iyy_q;
	assign izz  = izz_q;
	assign ixy  = ixy_q;
	assign ixz  = ixz_q;
	assign iyz  = iyz_q;

endmodule

`default_nettype wire

// ----- hdl/center_of_mass_inertia_tensor.sv -----
// Centre of mass and inertia tensor of a set of point masses.
//
// Particles arrive on the particle channel (valid/ready), one item a cycle while
// the block is loading. Each is written to the particle store and added into the
// running mass and mass-weighted position sums; a particle beyond MAX_PARTICLES is
// dropped and flags the set. The item marked last_particle closes the set.
// After the last item the block checks the set, divides the three weighted sums
// by the total mass in one shared divider, one axis after another, then reads the
// store back once, one particle a cycle, through a multiply and accumulate
// pipeline. The time a set takes is bound by the single store read port, which
// reads each particle back once after loading, and by the shared divider.
// A set with the flag or zero mass skips the arithmetic and goes straight from
// the check to the output, with all other fields zero.
// The result sits in an output register: a stalled receiver does not stop the
// loading of the next set, only its completion. Reset clears the running sums,
// counts and handshake state; the store holds no reset value and needs no clearing.
`default_nettype none
`include "assert_macros.svh"

module center_of_mass_inertia_tensor
	import cmit_pkg::*;
#(
	parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     particle_valid,
	output logic                          particle_ready,
	input  wire logic [MASS_W-1:0]        particle_mass,
	input  wire logic signed [POS_W-1:0]  pos_x,
	input  wire logic signed [POS_W-1:0]  pos_y,
	input  wire logic signed [POS_W-1:0]  pos_z,
	input  wire logic                     last_particle,
	output logic                          result_valid,
	input  wire logic                     result_ready,
	output logic [TMASS_W-1:0]            total_mass,
	output logic signed [POS_W-1:0]       center_x,
	output logic signed [POS_W-1:0]       center_y,
	output logic signed [POS_W-1:0]       center_z,
	output logic [DIAG_W-1:0]             inertia_xx,
	output logic [DIAG_W-1:0]             inertia_yy,
	output logic [DIAG_W-1:0]             inertia_zz,
	output logic signed [OFF_W-1:0]       inertia_xy,
	output logic signed [OFF_W-1:0]       inertia_xz,
	output logic signed [OFF_W-1:0]       inertia_yz,
	output logic [1:0]                    status
);

	localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);
	localparam int IDX_W  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int MSUM_W = MASS_W + CNT_W;
	localparam int WSUM_W = 32 + CNT_W;
	localparam int MP_W   = MASS_W + POS_W + 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PARTICLES);

	typedef enum logic [2:0] {
		S_LOAD,
		S_CHECK,
		S_DIV,
		S_WALK,
		S_DRAIN,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		AX_X,
		AX_Y,
		AX_Z
	} axis_t;

	state_t                   state_q;
	axis_t                    axis_q;
	logic                     div_start_q;
	logic [IDX_W-1:0]         rd_idx_q;
	logic                     rd_valid_s1;
	logic [CNT_W-1:0]         count_q;
	logic [MSUM_W-1:0]        mass_sum_q;
	logic signed [WSUM_W-1:0] wsum_x_q, wsum_y_q, wsum_z_q;
	logic                     overflow_q;
	status_t                  status_q;
	logic signed [POS_W-1:0]  cx_q, cy_q, cz_q;

	logic                     result_valid_q;
	status_t                  res_status_q;
	logic [TMASS_W-1:0]       total_mass_q;
	logic signed [POS_W-1:0]  center_x_q, center_y_q, center_z_q;
	logic [DIAG_W-1:0]        ixx_q, iyy_q, izz_q;
	logic signed [OFF_W-1:0]  ixy_q, ixz_q, iyz_q;

	logic                     accept;
	logic                     has_room;
	logic                     store_wr;
	logic                     rd_en;
	logic [ENTRY_W-1:0]       rd_data;
	logic signed [MASS_W:0]   m_sgn;
	logic signed [MP_W-1:0]   mpx_c, mpy_c, mpz_c;
	logic signed [WSUM_W-1:0] div_dividend;
	logic                     div_done;
	logic signed [POS_W-1:0]  div_quot;
	logic                     out_free;
	logic                     emit;
	logic                     div_start_c;
	logic                     walk_start;
	tp_ctrl_t                 tp_ctrl;
	logic                     tp_busy;
	logic [DIAG_W-1:0]        tp_ixx, tp_iyy, tp_izz;
	logic signed [OFF_W-1:0]  tp_ixy, tp_ixz, tp_iyz;

	assign particle_ready = (state_q == S_LOAD);
	assign accept         = particle_valid && particle_ready;
	assign has_room       = count_q < MAX_CNT;
	assign store_wr       = accept && has_room;
	assign rd_en          = (state_q == S_WALK);
	assign out_free       = !result_valid_q || result_ready;
	assign emit           = (state_q == S_EMIT) && out_free;
	assign walk_start     = (state_q == S_DIV) && div_done && (axis_q == AX_Z);

	// A divide starts after a clean check and after each axis but the last.
	assign div_start_c = ((state_q == S_CHECK) && !overflow_q && (mass_sum_q != '0)) ||
		((state_q == S_DIV) && div_done && (axis_q != AX_Z));

	assign m_sgn = {1'b0, particle_mass};
	assign mpx_c = m_sgn * pos_x;
	assign mpy_c = m_sgn * pos_y;
	assign mpz_c = m_sgn * pos_z;

	always_comb begin
		case (axis_q)
			AX_X:    div_dividend = wsum_x_q;
			AX_Y:    div_dividend = wsum_y_q;
			AX_Z:    div_dividend = wsum_z_q;
			default: div_dividend = wsum_x_q;
		endcase
	end

	assign tp_ctrl.clear = walk_start;
	assign tp_ctrl.valid = rd_valid_s1;

	// Writes happen only while loading and reads only while walking, so the two
	// ports never touch the same entry in the same cycle.
	cmit_store #(
		.MAX_PARTICLES(MAX_PARTICLES)
	) u_store (
		.clk     (clk),
		.wr_en   (store_wr),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (pack_entry(particle_mass, pos_x, pos_y, pos_z)),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q),
		.rd_data (rd_data)
	);

	cmit_div #(
		.MAX_PARTICLES(MAX_PARTICLES)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_dividend),
		.divisor  (mass_sum_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	cmit_tensor u_tensor (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (tp_ctrl),
		.entry  (rd_data),
		.cx     (cx_q),
		.cy     (cy_q),
		.cz     (cz_q),
		.busy   (tp_busy),
		.ixx    (tp_ixx),
		.iyy    (tp_iyy),
		.izz    (tp_izz),
		.ixy    (tp_ixy),
		.ixz    (tp_ixz),
		.iyz    (tp_iyz)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_LOAD;
			axis_q         <= AX_X;
			div_start_q    <= 1'b0;
			rd_idx_q       <= '0;
			rd_valid_s1    <= 1'b0;
			count_q        <= '0;
			mass_sum_q     <= '0;
			wsum_x_q       <= '0;
			wsum_y_q       <= '0;
			wsum_z_q       <= '0;
			overflow_q     <= 1'b0;
			status_q       <= ST_OK;
			cx_q           <= '0;
			cy_q           <= '0;
			cz_q           <= '0;
			result_valid_q <= 1'b0;
			res_status_q   <= ST_OK;
			total_mass_q   <= '0;
			center_x_q     <= '0;
			center_y_q     <= '0;
			center_z_q     <= '0;
			ixx_q          <= '0;
			iyy_q          <= '0;
			izz_q          <= '0;
			ixy_q          <= '0;
			ixz_q          <= '0;
			iyz_q          <= '0;
		end else begin
			div_start_q    <= div_start_c;
			rd_valid_s1    <= rd_en;
			result_valid_q <= emit || (result_valid_q && !result_ready);

			case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (has_room) begin
							count_q    <= count_q + 1'b1;
							mass_sum_q <= mass_sum_q + MSUM_W'(particle_mass);
							wsum_x_q   <= wsum_x_q + WSUM_W'(mpx_c);
							wsum_y_q   <= wsum_y_q + WSUM_W'(mpy_c);
							wsum_z_q   <= wsum_z_q + WSUM_W'(mpz_c);
						end else begin
							overflow_q <= 1'b1;
						end
						if (last_particle) begin
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (overflow_q) begin
						status_q <= ST_OVERFLOW;
						state_q  <= S_EMIT;
					end else if (mass_sum_q == '0) begin
						status_q <= ST_ZERO_MASS;
						state_q  <= S_EMIT;
					end else begin
						status_q <= ST_OK;
						axis_q   <= AX_X;
						state_q  <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						case (axis_q)
							AX_X: begin
								cx_q   <= div_quot;
								axis_q <= AX_Y;
							end
							AX_Y: begin
								cy_q   <= div_quot;
								axis_q <= AX_Z;
							end
							default: begin
								cz_q     <= div_quot;
								rd_idx_q <= '0;
								state_q  <= S_WALK;
							end
						endcase
					end
				end
				S_WALK: begin
					rd_idx_q <= rd_idx_q + 1'b1;
					if (CNT_W'(rd_idx_q) == count_q - 1'b1) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!rd_valid_s1 && !tp_busy) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						res_status_q <= status_q;
						if (status_q == ST_OK) begin
							total_mass_q <= TMASS_W'(mass_sum_q);
							center_x_q   <= cx_q;
							center_y_q   <= cy_q;
							center_z_q   <= cz_q;
							ixx_q        <= tp_ixx;
							iyy_q        <= tp_iyy;
							izz_q        <= tp_izz;
							ixy_q        <= tp_ixy;
							ixz_q        <= tp_ixz;
							iyz_q        <= tp_iyz;
						end else begin
							total_mass_q <= '0;
							center_x_q   <= '0;
							center_y_q   <= '0;
							center_z_q   <= '0;
							ixx_q        <= '0;
							iyy_q        <= '0;
							izz_q        <= '0;
							ixy_q        <= '0;
							ixz_q        <= '0;
							iyz_q        <= '0;
						end
						count_q    <= '0;
						mass_sum_q <= '0;
						wsum_x_q   <= '0;
						wsum_y_q   <= '0;
						wsum_z_q   <= '0;
						overflow_q <= 1'b0;
						state_q    <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign total_mass   = total_mass_q;
	assign center_x     = center_x_q;
	assign center_y     = center_y_q;
	assign center_z     = center_z_q;
	assign inertia_xx   = ixx_q;
	assign inertia_yy   = iyy_q;
	assign inertia_zz   = izz_q;
	assign inertia_xy   = ixy_q;
	assign inertia_xz   = ixz_q;
	assign inertia_yz   = iyz_q;
	assign status       = res_status_q;

	`ASSERT_IMPLY(a_read_written, rd_en, CNT_W'(rd_idx_q) < count_q, "store read past the particles of this set")
	`ASSERT_IMPLY(a_div_in_div, div_done, state_q == S_DIV, "divider finished outside the divide phase")
	`ASSERT_NEXT(a_emit_clears, (state_q == S_EMIT) && out_free, result_valid_q && (count_q == '0) && !overflow_q, "emitted item did not reset the set")
	`ASSERT_IMPLY(a_fault_zero, result_valid_q && (res_status_q != ST_OK), (total_mass_q == '0) && (ixx_q == '0) && (ixy_q == '0), "faulted item carries nonzero fields")

endmodule

`default_nettype wire
